/* rtl/sstr_pkg.sv */
// ---------------------------------------------------------------------------
// sstr_pkg: shared types and constants for the substring search block
// Register indexes, default parameter values and the text item layout.
// ---------------------------------------------------------------------------
package sstr_pkg;

	// default sizes
	localparam int PATTERN_MAX_DEF = 16;
	localparam int TEXT_MAX_DEF    = 65535;

	// pattern bytes that the pattern registers can hold
	localparam int PATTERN_REG_BYTES = 16;

	// configuration port
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int LENGTH_W    = 5;
	localparam int POSITION_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_PATTERN_LENGTH = 3'd2,
		REG_SEARCH_LAST    = 3'd3,
		REG_START_POSITION = 3'd4
	} cfg_reg_t;

	typedef logic [7:0] byte_t;

	// one text item as held in the input register
	typedef struct packed {
		byte_t data;
		logic  present;
		logic  last;
	} text_item_t;

endpackage

/* rtl/substring_search.sv */
// ---------------------------------------------------------------------------
// substring_search: streaming first / last substring search
// Compares a window of recent text bytes with a configured pattern of up to
// 16 bytes and reports one result at the end of each text string.
// ---------------------------------------------------------------------------
// usage
//   input channel: one item per text byte (text_byte, byte_present,
//   end_of_text), accepted when in_valid is high and in_stall is low. an item
//   with end_of_text set closes the text; byte_present low lets an item close
//   a text without adding a byte (so an empty text is one such item).
//   output channel: one item (found, match_position, overflow) per closed
//   text, taken when out_valid is high and out_stall is low.
//   configuration: cfg_write with cfg_index / cfg_data, one register per
//   cycle, only while no text is in flight.
//   throughput: one item per cycle unless a waiting result is stalled. the
//   final item of a text is captured in the input register, then one
//   compare / update pass writes its result into the result register.
//   stall: when out_stall holds a waiting result, the whole two-stage path
//   holds and in_stall rises once the input register is occupied.
//   reset: arst_n clears the configuration registers, valid flags and
//   per-text state; the pattern is then empty, so a text reports found at
//   position 0.
// ---------------------------------------------------------------------------
module substring_search #(
	parameter int PATTERN_MAX = sstr_pkg::PATTERN_MAX_DEF,
	parameter int TEXT_MAX    = sstr_pkg::TEXT_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_write,
	input  logic [sstr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sstr_pkg::CFG_DATA_W-1:0]    cfg_data,
	// text items
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         text_byte,
	input  logic                               byte_present,
	input  logic                               end_of_text,
	// results
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               found,
	output logic [sstr_pkg::POSITION_W-1:0]    match_position,
	output logic                               overflow
);

	// window depth: the usable pattern length
	localparam int WinDepth = (PATTERN_MAX < sstr_pkg::PATTERN_REG_BYTES) ?
		PATTERN_MAX : sstr_pkg::PATTERN_REG_BYTES;
	localparam int IdxW   = (WinDepth > 1) ? $clog2(WinDepth) : 1;
	localparam int CountW = $clog2(longint'(TEXT_MAX) + 64'd1);
	localparam int CmpW   = (CountW > sstr_pkg::POSITION_W) ? CountW : sstr_pkg::POSITION_W;
	localparam int LenW   = sstr_pkg::LENGTH_W;

	// configuration registers
	logic [63:0]                       pattern_low_q;
	logic [63:0]                       pattern_high_q;
	logic [LenW-1:0]                   pattern_length_q;
	logic                              search_last_q;
	logic [sstr_pkg::POSITION_W-1:0]   start_position_q;

	// input register
	logic                              valid_s1;
	sstr_pkg::text_item_t              item_s1;

	// per-text state
	sstr_pkg::byte_t                   window_q [WinDepth];
	logic [CountW-1:0]                 count_q;
	logic                              seen_q;
	logic [CountW-1:0]                 best_q;
	logic                              exceeded_q;

	// result register
	logic                              out_valid_q;
	logic                              found_q;
	logic [sstr_pkg::POSITION_W-1:0]   position_q;
	logic                              overflow_q;

	// datapath
	logic                              advance;
	logic [127:0]                      pattern;
	logic [LenW-1:0]                   plen;
	sstr_pkg::byte_t                   window_d [WinDepth];
	logic                              take_byte;
	logic                              full;
	logic [CountW-1:0]                 count_inc;
	logic                              window_match;
	logic [CmpW-1:0]                   count_ext;
	logic [CmpW-1:0]                   plen_ext;
	logic [CmpW-1:0]                   start_ext;
	logic [CmpW-1:0]                   pos_ext;
	logic [CmpW-1:0]                   best_ext;
	logic                              hit;
	logic                              seen_d;
	logic [CountW-1:0]                 best_d;
	logic                              exceeded_d;

	// ------------------------------------------------------------------
	// configuration writes; indexes past the list are ignored
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= '0;
			search_last_q    <= 1'b0;
			start_position_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				sstr_pkg::REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				sstr_pkg::REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				sstr_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LenW-1:0];
				sstr_pkg::REG_SEARCH_LAST:    search_last_q    <= cfg_data[0];
				sstr_pkg::REG_START_POSITION: start_position_q <= cfg_data[sstr_pkg::POSITION_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// handshake: both stages move together unless a result waits
	// ------------------------------------------------------------------
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.data    <= text_byte;
			item_s1.present <= byte_present;
			item_s1.last    <= end_of_text;
		end
	end

	// ------------------------------------------------------------------
	// window compare and match bookkeeping for the item in stage 1
	// ------------------------------------------------------------------
	assign pattern = {pattern_high_q, pattern_low_q};

	// saturate the pattern length to the window depth
	assign plen = (pattern_length_q > LenW'(WinDepth)) ? LenW'(WinDepth) : pattern_length_q;

	// bytes past the text limit are dropped and flagged
	assign full      = (count_q >= CountW'(TEXT_MAX));
	assign take_byte = valid_s1 && item_s1.present && !full;
	assign count_inc = count_q + CountW'(1);

	// window after shifting in the new byte, newest at entry 0
	always_comb begin
		window_d[0] = item_s1.data;
		for (int k = 1; k < WinDepth; k++) begin
			window_d[k] = window_q[k-1];
		end
	end

	// pattern byte i lines up with window entry plen-1-i
	always_comb begin
		window_match = 1'b1;
		for (int i = 0; i < WinDepth; i++) begin
			if (LenW'(i) < plen) begin
				if (window_d[IdxW'(plen - LenW'(1) - LenW'(i))] != pattern[8*i +: 8]) begin
					window_match = 1'b0;
				end
			end
		end
	end

	assign count_ext = CmpW'(count_inc);
	assign plen_ext  = CmpW'(plen);
	assign start_ext = CmpW'(start_position_q);
	assign pos_ext   = count_ext - plen_ext;

	// last mode keeps the latest match ending at or before the limit;
	// first mode locks onto the earliest match at or after the start
	always_comb begin
		hit = 1'b0;
		if (take_byte && (plen != '0) && (count_ext >= plen_ext) && window_match) begin
			if (search_last_q) begin
				hit = (start_ext != '0) && (count_ext <= start_ext);
			end else begin
				hit = !seen_q && (pos_ext >= start_ext);
			end
		end
	end

	assign seen_d     = seen_q || hit;
	assign best_d     = hit ? pos_ext[CountW-1:0] : best_q;
	assign exceeded_d = exceeded_q || (valid_s1 && item_s1.present && full);
	assign best_ext   = CmpW'(best_d);

	always_ff @(posedge clk) begin
		if (advance && take_byte) begin
			for (int k = 0; k < WinDepth; k++) begin
				window_q[k] <= window_d[k];
			end
		end
	end

	// per-text state, cleared after the final item of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			seen_q     <= 1'b0;
			best_q     <= '0;
			exceeded_q <= 1'b0;
		end else if (advance && valid_s1) begin
			if (item_s1.last) begin
				count_q    <= '0;
				seen_q     <= 1'b0;
				best_q     <= '0;
				exceeded_q <= 1'b0;
			end else begin
				if (take_byte) begin
					count_q <= count_inc;
				end
				seen_q     <= seen_d;
				best_q     <= best_d;
				exceeded_q <= exceeded_d;
			end
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && item_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && item_s1.last) begin
			// an empty pattern always matches at the start
			if (plen == '0) begin
				found_q    <= 1'b1;
				position_q <= '0;
			end else if (seen_d) begin
				found_q    <= 1'b1;
				position_q <= best_ext[sstr_pkg::POSITION_W-1:0];
			end else begin
				found_q    <= 1'b0;
				position_q <= '0;
			end
			overflow_q <= exceeded_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign match_position = position_q;
	assign overflow       = overflow_q;

endmodule
